// File: rtl/altpid_pkg.sv
// Shared constants and register map for the altitude thrust controller.
`default_nettype none
package altpid_pkg;

	// register map, index = paddr[4:2]
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_KP_POSITION  = 3'd0;
	localparam logic [IDX_W-1:0] REG_KP_VELOCITY  = 3'd1;
	localparam logic [IDX_W-1:0] REG_KI_POSITION  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_ASCENT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_DESCENT  = 3'd4;
	localparam logic [IDX_W-1:0] REG_VEHICLE_MASS = 3'd5;
	localparam logic [IDX_W-1:0] REG_TIME_STEP    = 3'd6;

	// register reset values
	localparam logic [30:0] MAX_ASCENT_RST   = 31'd6553600;
	localparam logic [30:0] MAX_DESCENT_RST  = 31'd6553600;
	localparam logic [30:0] VEHICLE_MASS_RST = 31'd65536;
	localparam logic [16:0] TIME_STEP_RST    = 17'd1311;

	// 9.81 in Q16.16
	localparam logic signed [50:0] GRAVITY_Q = 51'sd642908;
	// 1.0 in Q.28
	localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
	// largest time step, 1.0 s
	localparam logic [16:0] DT_MAX = 17'd65536;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

	// quotient bits of the thrust division
	localparam int unsigned QUO_W = 31;
	localparam logic [4:0]  DIV_LAST = 5'(QUO_W - 1);

endpackage
`default_nettype wire

// File: rtl/altitude_pid_thrust.sv
// Altitude PID controller with feed-forward, producing a collective thrust command.
`default_nettype none
// One input beat is one control tick; one output beat carries the thrust command and a
// saturation flag. All arithmetic runs through one shared 33x33 signed multiplier under a
// small sequencer: the integrator product (two partial products), the three gain terms,
// qx^2 and qy^2, and mass*accel, one multiply per cycle. The tilt division then runs as a
// restoring divider for the 31 quotient bits, one quotient bit per cycle. A tick with a
// non-positive tilt factor or a clipped thrust skips the divider. The input is not ready
// while a tick is in work. A finished result sits in the output register, so the next
// tick is accepted while it waits to be taken. Register writes are only legal while no
// tick is in flight. The integrator state resets to zero.
module altitude_pid_thrust (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s_tdata, low bit up: target_height[31:0], target_climb[63:32],
	// measured_height[95:64], measured_climb[127:96], feedforward_accel[159:128],
	// quat_w[175:160], quat_x[191:176], quat_y[207:192], quat_z[223:208]
	input  wire logic [223:0] s_tdata,
	// output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m_tdata, low bit up: thrust_command[31:0]
	output logic [31:0]       m_tdata,
	// m_tuser, low bit up: saturated[0]
	output logic              m_tuser,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [altpid_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,   // height error, climb clamp
		ST_SUM,   // integrator update, velocity error
		ST_MLO,   // mul: sum low half * dt
		ST_MHI,   // mul: sum high half * dt
		ST_MKP,   // mul: kp * e
		ST_MKV,   // mul: kv * ev, integral value
		ST_MKI,   // mul: ki * i
		ST_MQX,   // mul: qx * qx
		ST_MQY,   // mul: qy * qy, add feed-forward
		ST_AST,   // accel minus gravity
		ST_MMS,   // mul: mass * a, tilt factor
		ST_PMAG,  // magnitude, range checks, divider setup
		ST_DIV,   // one quotient bit per cycle
		ST_DVE,   // apply sign
		ST_FIN    // hand result to output register
	} state_t;

	state_t state_q;

	// configuration registers
	logic [30:0] kp_position_q, kp_velocity_q, ki_position_q;
	logic [30:0] max_ascent_q, max_descent_q, vehicle_mass_q;
	logic [16:0] time_step_q;

	// latched input fields
	logic signed [31:0] th_q, tc_q, mh_q, mc_q, ff_q;
	logic signed [15:0] qx_q, qy_q;

	// datapath
	logic signed [47:0] sum_q;
	logic signed [32:0] e_q, vc_q, ev_q;
	logic signed [31:0] e32_q, ev32_q, id_q, a_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [49:0] u_q;
	logic        [31:0] r_q;
	logic signed [33:0] r22_q;
	logic        [28:0] rem_q;
	logic        [2:0]  dbits_q;
	logic        [altpid_pkg::QUO_W-1:0] quo_q;
	logic        [4:0]  cnt_q;
	logic               neg_q;
	logic               sat_q;
	logic signed [31:0] thrust_q;
	logic               m_tvalid_q;
	logic        [31:0] m_tdata_q;
	logic               m_tuser_q;

	// ---------------------------------------------------------------- config port
	logic                         cfg_wr;
	logic [altpid_pkg::IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[altpid_pkg::ADDR_W-1:2];

	always_comb begin
		case (cfg_idx)
			altpid_pkg::REG_KP_POSITION:  prdata = {1'b0, kp_position_q};
			altpid_pkg::REG_KP_VELOCITY:  prdata = {1'b0, kp_velocity_q};
			altpid_pkg::REG_KI_POSITION:  prdata = {1'b0, ki_position_q};
			altpid_pkg::REG_MAX_ASCENT:   prdata = {1'b0, max_ascent_q};
			altpid_pkg::REG_MAX_DESCENT:  prdata = {1'b0, max_descent_q};
			altpid_pkg::REG_VEHICLE_MASS: prdata = {1'b0, vehicle_mass_q};
			altpid_pkg::REG_TIME_STEP:    prdata = {15'd0, time_step_q};
			default:                      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_position_q  <= '0;
			kp_velocity_q  <= '0;
			ki_position_q  <= '0;
			max_ascent_q   <= altpid_pkg::MAX_ASCENT_RST;
			max_descent_q  <= altpid_pkg::MAX_DESCENT_RST;
			vehicle_mass_q <= altpid_pkg::VEHICLE_MASS_RST;
			time_step_q    <= altpid_pkg::TIME_STEP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				altpid_pkg::REG_KP_POSITION:  kp_position_q  <= pwdata[30:0];
				altpid_pkg::REG_KP_VELOCITY:  kp_velocity_q  <= pwdata[30:0];
				altpid_pkg::REG_KI_POSITION:  ki_position_q  <= pwdata[30:0];
				altpid_pkg::REG_MAX_ASCENT:   max_ascent_q   <= pwdata[30:0];
				altpid_pkg::REG_MAX_DESCENT:  max_descent_q  <= pwdata[30:0];
				altpid_pkg::REG_VEHICLE_MASS: vehicle_mass_q <= pwdata[30:0];
				altpid_pkg::REG_TIME_STEP:    time_step_q    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic        [16:0] dt;

	// time steps above 1.0 s act as 1.0 s
	assign dt = (time_step_q > altpid_pkg::DT_MAX) ? altpid_pkg::DT_MAX : time_step_q;

	always_comb begin
		case (state_q)
			ST_MLO: begin
				mul_a = {9'd0, sum_q[23:0]};
				mul_b = {16'd0, dt};
			end
			ST_MHI: begin
				mul_a = {{9{sum_q[47]}}, sum_q[47:24]};
				mul_b = {16'd0, dt};
			end
			ST_MKP: begin
				mul_a = {2'b00, kp_position_q};
				mul_b = {e32_q[31], e32_q};
			end
			ST_MKV: begin
				mul_a = {2'b00, kp_velocity_q};
				mul_b = {ev32_q[31], ev32_q};
			end
			ST_MKI: begin
				mul_a = {2'b00, ki_position_q};
				mul_b = {id_q[31], id_q};
			end
			ST_MQX: begin
				mul_a = {{17{qx_q[15]}}, qx_q};
				mul_b = {{17{qx_q[15]}}, qx_q};
			end
			ST_MQY: begin
				mul_a = {{17{qy_q[15]}}, qy_q};
				mul_b = {{17{qy_q[15]}}, qy_q};
			end
			ST_MMS: begin
				mul_a = {2'b00, vehicle_mass_q};
				mul_b = {a_q[31], a_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---------------------------------------------------------------- step logic
	logic signed [32:0] tc_ext, neg_asc, pos_desc, vc_lo, vc_nxt;
	logic signed [48:0] sum_w;
	logic               sum_ovf;
	logic               e_ovf, ev_ovf, id_ovf, a_ovf;
	logic signed [50:0] a_w;
	logic signed [49:0] p_w, p_abs;
	logic        [46:0] mag;
	logic               p_pos, r22_pos, mag_big;
	logic        [29:0] trial;
	logic        [30:0] trial_d;
	logic               qbit;

	always_comb begin
		// climb clamp to [-max_ascent, max_descent], descent limit wins
		tc_ext   = {tc_q[31], tc_q};
		neg_asc  = -$signed({2'b00, max_ascent_q});
		pos_desc = $signed({2'b00, max_descent_q});
		vc_lo    = (tc_ext < neg_asc) ? neg_asc : tc_ext;
		vc_nxt   = (vc_lo > pos_desc) ? pos_desc : vc_lo;

		sum_w   = {sum_q[47], sum_q} + {{16{e_q[32]}}, e_q};
		sum_ovf = sum_w[48] != sum_w[47];
		e_ovf   = e_q[32] != e_q[31];
		ev_ovf  = ev_q[32] != ev_q[31];
		id_ovf  = !((&acc_q[65:47]) || !(|acc_q[65:47]));

		a_w   = {u_q[49], u_q} - altpid_pkg::GRAVITY_Q;
		a_ovf = !((&a_w[50:31]) || !(|a_w[50:31]));

		p_w     = prod_q[65:16];
		p_abs   = p_w[49] ? -p_w : p_w;
		mag     = p_abs[46:0];
		p_pos   = !p_w[49] && (p_w != '0);
		r22_pos = !r22_q[33] && (r22_q != '0);
		mag_big = mag >= {15'd0, r22_q[28:0], 3'b000};

		trial   = {rem_q, dbits_q[2]};
		trial_d = {1'b0, trial} - {2'b00, r22_q[28:0]};
		qbit    = !trial_d[30];
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			prod_q <= mul_p;
			// beat taken; ST_FIN reloads the register itself
			if (m_tready && state_q != ST_FIN)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						th_q    <= s_tdata[31:0];
						tc_q    <= s_tdata[63:32];
						mh_q    <= s_tdata[95:64];
						mc_q    <= s_tdata[127:96];
						ff_q    <= s_tdata[159:128];
						qx_q    <= s_tdata[191:176];
						qy_q    <= s_tdata[207:192];
						sat_q   <= 1'b0;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					e_q     <= {th_q[31], th_q} - {mh_q[31], mh_q};
					vc_q    <= vc_nxt;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (sum_ovf)
						sum_q <= sum_w[48] ? altpid_pkg::S48_MIN : altpid_pkg::S48_MAX;
					else
						sum_q <= sum_w[47:0];
					ev_q <= vc_q - {mc_q[31], mc_q};
					if (e_ovf)
						e32_q <= e_q[32] ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
					else
						e32_q <= e_q[31:0];
					sat_q   <= sat_q | sum_ovf | e_ovf;
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					if (ev_ovf)
						ev32_q <= ev_q[32] ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
					else
						ev32_q <= ev_q[31:0];
					sat_q   <= sat_q | ev_ovf;
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					acc_q   <= prod_q;
					state_q <= ST_MKP;
				end
				ST_MKP: begin
					// high partial product weighs 2^24
					acc_q   <= acc_q + {prod_q[41:0], 24'd0};
					state_q <= ST_MKV;
				end
				ST_MKV: begin
					if (id_ovf)
						id_q <= acc_q[65] ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
					else
						id_q <= acc_q[47:16];
					sat_q   <= sat_q | id_ovf;
					u_q     <= prod_q[65:16];
					state_q <= ST_MKI;
				end
				ST_MKI: begin
					u_q     <= u_q + prod_q[65:16];
					state_q <= ST_MQX;
				end
				ST_MQX: begin
					u_q     <= u_q + prod_q[65:16];
					state_q <= ST_MQY;
				end
				ST_MQY: begin
					u_q     <= u_q + {{18{ff_q[31]}}, ff_q};
					r_q     <= prod_q[31:0];
					state_q <= ST_AST;
				end
				ST_AST: begin
					if (a_ovf)
						a_q <= a_w[50] ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
					else
						a_q <= a_w[31:0];
					sat_q   <= sat_q | a_ovf;
					r_q     <= r_q + prod_q[31:0];
					state_q <= ST_MMS;
				end
				ST_MMS: begin
					r22_q   <= altpid_pkg::ONE_Q28 - $signed({1'b0, r_q, 1'b0});
					state_q <= ST_PMAG;
				end
				ST_PMAG: begin
					if (!r22_pos) begin
						// tilted to or past horizontal: no thrust
						thrust_q <= '0;
						sat_q    <= 1'b1;
						state_q  <= ST_FIN;
					end else if (mag_big) begin
						thrust_q <= p_pos ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
						sat_q    <= 1'b1;
						state_q  <= ST_FIN;
					end else begin
						// quotient of mag*2^28/r22 fits 31 bits; mag>>3 < r22
						rem_q   <= {1'b0, mag[30:3]};
						dbits_q <= mag[2:0];
						quo_q   <= '0;
						cnt_q   <= altpid_pkg::DIV_LAST;
						neg_q   <= p_pos;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q   <= qbit ? trial_d[28:0] : trial[28:0];
					dbits_q <= {dbits_q[1:0], 1'b0};
					quo_q   <= {quo_q[altpid_pkg::QUO_W-2:0], qbit};
					cnt_q   <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= ST_DVE;
				end
				ST_DVE: begin
					thrust_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= thrust_q;
						m_tuser_q  <= sat_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the altitude thrust controller: stream in, stream out, APB setup.
`default_nettype none
module tb;

	// index that maps to no register, writes to it must be dropped
	localparam logic [altpid_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int IDLE_PCT  = 14;
	localparam int HOLD_LEN  = 400;
	localparam int SETTLE    = 60;   // quiet time after the last result is back

	// one tick, first member in the top bits, so a cast matches s_tdata
	typedef struct packed {
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_w;
		logic signed [31:0] feedforward_accel;
		logic signed [31:0] measured_climb;
		logic signed [31:0] measured_height;
		logic signed [31:0] target_climb;
		logic signed [31:0] target_height;
	} tick_t;

	typedef struct packed {
		logic [31:0] thr;
		logic        sat;
	} thrust_out_t;

	// per tick: whether the result is typed in by hand, and that result
	typedef struct packed {
		bit          known;
		thrust_out_t fixed;
	} tick_note_t;

	typedef struct packed {
		tick_t      tick;
		tick_note_t note;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [223:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [altpid_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	altitude_pid_thrust DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the register file and the integrator
	logic [30:0] gain_pos = 31'd0;
	logic [30:0] gain_vel = 31'd0;
	logic [30:0] gain_int = 31'd0;
	logic [30:0] lim_up   = altpid_pkg::MAX_ASCENT_RST;
	logic [30:0] lim_down = altpid_pkg::MAX_DESCENT_RST;
	logic [30:0] mass_q   = altpid_pkg::VEHICLE_MASS_RST;
	logic [16:0] tick_dt  = altpid_pkg::TIME_STEP_RST;
	logic signed [47:0] height_err_acc = '0;

	tick_note_t  tick_notes_q[$];
	thrust_out_t thrust_due_q[$];

	int  idle_pct = IDLE_PCT;
	bit  stall_req = 1'b0;
	bit  stall_done = 1'b0;
	int  hold_cnt = 0;
	int  n_errors = 0;
	int  n_checked = 0;
	int  n_ticks = 0;
	int  n_settings = 0;
	int  n_windup = 0;

	function automatic logic signed [79:0] clip_to(input logic signed [79:0] v,
			input logic signed [79:0] lo, input logic signed [79:0] hi, inout bit hit);
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		return v;
	endfunction

	// one control tick: integrator update, PID sum, tilt-compensated thrust
	function automatic thrust_out_t predict_thrust(input tick_t t);
		logic signed [79:0] e, vc, ev, e32, ev32, acc, dtv, iv, u, ffv, a;
		logic signed [79:0] qx, qy, r22, p, mag, q;
		logic signed [79:0] kpp, kvv, kii, up, down, ms;
		thrust_out_t r;
		bit hit;
		hit = 1'b0;
		kpp = {49'd0, gain_pos};
		kvv = {49'd0, gain_vel};
		kii = {49'd0, gain_int};
		up = {49'd0, lim_up};
		down = {49'd0, lim_down};
		ms = {49'd0, mass_q};

		e = t.target_height;
		e = e - t.measured_height;
		acc = height_err_acc;
		acc = clip_to(acc + e, altpid_pkg::S48_MIN, altpid_pkg::S48_MAX, hit);
		height_err_acc = acc[47:0];

		// limit clamp on the climb setpoint never flags
		vc = t.target_climb;
		if (vc < -up)
			vc = -up;
		if (vc > down)
			vc = down;
		ev = vc - t.measured_climb;

		e32 = clip_to(e, altpid_pkg::S32_MIN, altpid_pkg::S32_MAX, hit);
		ev32 = clip_to(ev, altpid_pkg::S32_MIN, altpid_pkg::S32_MAX, hit);

		dtv = (tick_dt > altpid_pkg::DT_MAX) ? {63'd0, altpid_pkg::DT_MAX} : {63'd0, tick_dt};
		iv = acc * dtv;
		iv = clip_to(iv >>> 16, altpid_pkg::S32_MIN, altpid_pkg::S32_MAX, hit);

		ffv = t.feedforward_accel;
		u = ((kpp * e32) >>> 16) + ((kvv * ev32) >>> 16) + ((kii * iv) >>> 16) + ffv;
		a = clip_to(u - altpid_pkg::GRAVITY_Q, altpid_pkg::S32_MIN, altpid_pkg::S32_MAX, hit);

		qx = t.quat_x;
		qy = t.quat_y;
		r22 = altpid_pkg::ONE_Q28 - 2 * (qx * qx + qy * qy);
		if (r22 <= 0) begin
			hit = 1'b1;
			r.thr = 32'd0;
		end else begin
			p = (ms * a) >>> 16;
			mag = (p < 0) ? -p : p;
			if (mag >= 8 * r22) begin
				hit = 1'b1;
				r.thr = (p > 0) ? altpid_pkg::S32_MIN : altpid_pkg::S32_MAX;
			end else begin
				q = (mag <<< 28) / r22;
				r.thr = (p > 0) ? 32'(-q) : 32'(q);
			end
		end
		r.sat = hit;
		return r;
	endfunction

	// input side: every accepted beat is predicted in order
	always @(posedge clk) begin : take_in
		tick_note_t  note;
		thrust_out_t want;
		if (arst_n && s_tvalid && s_tready) begin
			note = tick_notes_q.pop_front();
			want = predict_thrust(tick_t'(s_tdata));
			thrust_due_q.push_back(note.known ? note.fixed : want);
		end
	end

	// output side: compare each beat with the oldest expectation
	always @(posedge clk) begin : take_out
		thrust_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (thrust_due_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected beat, expected none, actual thrust %h sat %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = thrust_due_q.pop_front();
				n_checked++;
				if (m_tdata !== want.thr) begin
					n_errors++;
					$display("%0t: thrust expected %h actual %h", $time, want.thr, m_tdata);
				end
				if (m_tuser !== want.sat) begin
					n_errors++;
					$display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser);
				end
			end
		end
	end

	// receiver: random back-pressure, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (stall_req && !stall_done) begin
			m_tready <= 1'b0;
			hold_cnt <= HOLD_LEN;
			stall_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// setup and access phase, register taken on the access edge, then the bus idles before return
	task automatic apb_write(input logic [altpid_pkg::IDX_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			altpid_pkg::REG_KP_POSITION:  gain_pos = val[30:0];
			altpid_pkg::REG_KP_VELOCITY:  gain_vel = val[30:0];
			altpid_pkg::REG_KI_POSITION:  gain_int = val[30:0];
			altpid_pkg::REG_MAX_ASCENT:   lim_up   = val[30:0];
			altpid_pkg::REG_MAX_DESCENT:  lim_down = val[30:0];
			altpid_pkg::REG_VEHICLE_MASS: mass_q   = val[30:0];
			altpid_pkg::REG_TIME_STEP:    tick_dt  = val[16:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] kp, input logic [31:0] kv,
			input logic [31:0] ki, input logic [31:0] up, input logic [31:0] down,
			input logic [31:0] ms, input logic [31:0] ts);
		apb_write(altpid_pkg::REG_KP_POSITION, kp);
		apb_write(altpid_pkg::REG_KP_VELOCITY, kv);
		apb_write(altpid_pkg::REG_KI_POSITION, ki);
		apb_write(altpid_pkg::REG_MAX_ASCENT, up);
		apb_write(altpid_pkg::REG_MAX_DESCENT, down);
		apb_write(altpid_pkg::REG_VEHICLE_MASS, ms);
		apb_write(altpid_pkg::REG_TIME_STEP, ts);
		n_settings++;
	endtask

	// offer one beat; returns at the edge that takes it
	task automatic send_tick(input tick_t t, input tick_note_t note);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		tick_notes_q.push_back(note);
		s_tvalid <= 1'b1;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_ticks++;
	endtask

	// all results back and the pipe quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (thrust_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic dir_row_t mk_row(input int th, input int tc, input int mh, input int mc,
			input int ff, input shortint qw, input shortint qx, input shortint qy,
			input shortint qz, input bit known, input logic [31:0] thr, input bit sat);
		dir_row_t r;
		r.tick.target_height = th;
		r.tick.target_climb = tc;
		r.tick.measured_height = mh;
		r.tick.measured_climb = mc;
		r.tick.feedforward_accel = ff;
		r.tick.quat_w = qw;
		r.tick.quat_x = qx;
		r.tick.quat_y = qy;
		r.tick.quat_z = qz;
		r.note.known = known;
		r.note.fixed.thr = thr;
		r.note.fixed.sat = sat;
		return r;
	endfunction

	function automatic int span(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic shortint quat_any();
		return shortint'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// mostly plausible flight values, some raw noise over the whole range of the 32-bit fields
	function automatic tick_t mk_tick();
		tick_t t;
		if ($urandom_range(99) < 75) begin
			t.target_height = span(1 << 24);
			t.measured_height = t.target_height + span(1 << 18);
			t.target_climb = span(1 << 22);
			t.measured_climb = span(1 << 22);
			t.feedforward_accel = span(1 << 21);
			t.quat_x = shortint'(span(9000));
			t.quat_y = shortint'(span(9000));
		end else begin
			t.target_height = $urandom;
			t.measured_height = $urandom;
			t.target_climb = $urandom;
			t.measured_climb = $urandom;
			t.feedforward_accel = $urandom;
			t.quat_x = quat_any();
			t.quat_y = quat_any();
		end
		t.quat_w = quat_any();
		t.quat_z = quat_any();
		return t;
	endfunction

	// gain with a random bit 31 that the register must drop
	function automatic logic [31:0] pick_gain();
		logic [31:0] g;
		case ($urandom_range(3))
			0: g = $urandom_range(0, 262144);
			1: g = $urandom_range(0, 65536);
			2: g = $urandom;
			default: g = 32'h7FFF_FFFF;
		endcase
		g[31] = $urandom_range(1);
		return g;
	endfunction

	function automatic logic [31:0] pick_limit();
		return ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 24);
	endfunction

	initial begin : main
		dir_row_t   dir_rows[$];
		tick_t      t;
		tick_note_t none;
		none = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed rows, reset settings: zero gains, unit mass, 1.0 tilt ---
		// plain gravity compensation
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd642908, 0));
		// feed-forward cancels gravity
		dir_rows.push_back(mk_row(0, 0, 0, 0, 642908, 0, 0, 0, 0, 1, 32'd0, 0));
		dir_rows.push_back(mk_row(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0,
			1, 32'h8009_CF5D, 0));
		// accel clips low, then thrust magnitude clips
		dir_rows.push_back(mk_row(0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0,
			1, 32'h7FFF_FFFF, 1));
		// tilt factor negative
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 16384, 0, 0, 1, 32'd0, 1));
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, -16384, -16384, 0, 1, 32'd0, 1));
		// tilt factor exactly zero
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 8192, 8192, 0, 1, 32'd0, 1));
		// tiny positive tilt factor, thrust overflows
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 11585, 0, 1, 32'h7FFF_FFFF, 1));
		// height error too wide for 32 bits, both signs
		dir_rows.push_back(mk_row(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0,
			1, 32'd642908, 1));
		dir_rows.push_back(mk_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0,
			1, 32'd642908, 1));
		// climb setpoint beyond the limit is clamped without a flag
		dir_rows.push_back(mk_row(0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 32'd642908, 0));
		// velocity error too wide, both signs
		dir_rows.push_back(mk_row(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0,
			1, 32'd642908, 1));
		dir_rows.push_back(mk_row(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0,
			1, 32'd642908, 1));
		// w and z play no part
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 16384, 0, 0, -16384, 1, 32'd642908, 0));
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, -16384, 0, 0, 16384, 1, 32'd642908, 0));
		// predictor-checked rows
		dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, -1, 1, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(32'h0010_0000, -200000, -524288, 1000, -300000,
			15000, 3000, -4000, -200, 0, '0, 0));
		dir_rows.push_back(mk_row(0, 0, 0, 0, -1, 0, 11000, 3000, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(123456, 5, -77, 9, 32'h4000_0000, 1, -7000, 7000, 2,
			0, '0, 0));
		foreach (dir_rows[i])
			send_tick(dir_rows[i].tick, dir_rows[i].note);
		drain();

		// --- integrator driven far past the 32-bit integral range, then back ---
		// dt of 1.0 s makes the integral value the sum itself; the error stays in 32 bits
		write_all(32'd0, 32'd0, 32'd1, altpid_pkg::MAX_ASCENT_RST, altpid_pkg::MAX_DESCENT_RST,
			altpid_pkg::VEHICLE_MASS_RST, 32'd65536);
		t = '0;
		t.target_height = 32'sh3FFF_FFFF;
		t.measured_height = 32'shC000_0000;
		repeat (12) begin
			send_tick(t, none);
			n_windup++;
		end
		t.target_height = 32'shC000_0000;
		t.measured_height = 32'sh3FFF_FFFF;
		repeat (28) begin
			send_tick(t, none);
			n_windup++;
		end
		drain();

		// --- register extremes: all ones, masked to field width ---
		write_all('1, '1, '1, '1, '1, '1, '1);
		apb_write(REG_UNUSED, $urandom);
		repeat (250) send_tick(mk_tick(), none);
		drain();

		// --- smallest legal settings ---
		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
		repeat (200) send_tick(mk_tick(), none);
		drain();

		// --- random settings; one phase without idling, one with a long hold-off ---
		for (int ph = 0; ph < 5; ph++) begin
			write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
				($urandom_range(3) == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
					: $urandom_range(1, 1 << 20),
				$urandom_range(1, 131071) | ($urandom & 32'hFFFE_0000));
			if (ph == 2)
				apb_write(REG_UNUSED, $urandom);
			idle_pct <= (ph == 1) ? 0 : IDLE_PCT;
			for (int k = 0; k < 270; k++) begin
				if (ph == 3 && k == 40)
					stall_req <= 1'b1;
				send_tick(mk_tick(), none);
			end
			drain();
		end

		$display("ran %0d ticks (%0d in integrator windup) over %0d register settings, %0d results checked",
			n_ticks, n_windup, n_settings, n_checked);
		$display("covered tilt, thrust, error and integral clipping, masked registers, %0d-cycle hold-off",
			HOLD_LEN);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
